FILE: rtl/core/char_lcd_text_cursor_writer_top_assert.svh
// Assertion macros used by the port-level checker of the LCD text writer
`ifndef CHAR_LCD_TEXT_CURSOR_WRITER_TOP_ASSERT_SVH
`define CHAR_LCD_TEXT_CURSOR_WRITER_TOP_ASSERT_SVH

// Clocked assertion, switched off while reset is held
`define LCDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define LCDW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/lcdw_pkg.sv
// Types and constants of the LCD text and cursor writer
package lcdw_pkg;

  typedef enum logic {
    ACT_PRINT  = 1'b0,
    ACT_CURSOR = 1'b1
  } action_e;

  typedef enum logic {
    RS_CMD  = 1'b0,
    RS_DATA = 1'b1
  } reg_sel_e;

  localparam logic [1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [1:0] CFG_NUM_COLS = 2'd1;
  localparam logic [1:0] CFG_WRAP_EN  = 2'd2;

  localparam logic [2:0] NUM_ROWS_RST = 3'd2;
  localparam logic [6:0] NUM_COLS_RST = 7'd16;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CH_NEWLINE    = 8'd10;
  localparam logic [7:0] CH_RETURN     = 8'd13;
  localparam logic [7:0] COL_MAX       = 8'hFF;

  localparam logic [6:0] ROW_BASE [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

  // One queued request: one or two bus bytes, first byte sent first
  typedef struct packed {
    logic [7:0] byte0;
    reg_sel_e   rs0;
    logic [7:0] byte1;
    reg_sel_e   rs1;
    logic       two;
  } byte_req_t;

  // Row at or past the row count (or past the last display row) goes to row 0
  function automatic logic [1:0] fix_row(logic [2:0] r, logic [2:0] nrows);
    fix_row = ((r >= nrows) || (r > 3'd3)) ? 2'd0 : r[1:0];
  endfunction

  function automatic logic [7:0] addr_cmd(logic [1:0] r, logic [7:0] c);
    logic [6:0] sum;
    sum      = c[6:0] + ROW_BASE[r];
    addr_cmd = CMD_SET_DDRAM | {1'b0, sum};
  endfunction

endpackage

FILE: rtl/core/lcdw_in_if.sv
// Request channel carrying print and cursor-set items
interface lcdw_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;
  logic [1:0] row;
  logic [6:0] col;

  modport source (output valid, action, char_code, row, col, input ready);
  modport sink   (input valid, action, char_code, row, col, output ready);
endinterface

FILE: rtl/core/lcdw_out_if.sv
// Nibble channel towards the 4-bit LCD bus driver
interface lcdw_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] nibble;
  logic       reg_select;
  logic       last;

  modport source (output valid, nibble, reg_select, last, input ready);
  modport sink   (input valid, nibble, reg_select, last, output ready);
endinterface

FILE: rtl/core/lcdw_front.sv
// Front end: takes requests, keeps the cursor and turns each request into bus bytes
module lcdw_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [6:0]         cfg_data_i,
  lcdw_in_if.sink            in_req,
  output logic               push_o,
  output lcdw_pkg::byte_req_t push_req_o,
  input  logic               push_ready_i
);

  logic [2:0] num_rows_q;
  logic [6:0] num_cols_q;
  logic       wrap_en_q;
  logic [7:0] col_q, col_d;
  logic [1:0] row_q, row_d;

  logic       wrap;
  logic [1:0] row_w;
  logic [7:0] col_w;
  logic [7:0] wrap_byte;
  logic [7:0] char_byte;
  lcdw_pkg::reg_sel_e char_rs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= lcdw_pkg::NUM_ROWS_RST;
      num_cols_q <= lcdw_pkg::NUM_COLS_RST;
      wrap_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcdw_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data_i[2:0];
        lcdw_pkg::CFG_NUM_COLS: num_cols_q <= cfg_data_i;
        lcdw_pkg::CFG_WRAP_EN:  wrap_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_req.ready = push_ready_i;
  assign push_o       = in_req.valid && push_ready_i;

  always_comb begin
    // wrap mode first starts a new line, then the character works on that cursor
    wrap      = wrap_en_q && (col_q >= {1'b0, num_cols_q});
    row_w     = wrap ? lcdw_pkg::fix_row({1'b0, row_q} + 3'd1, num_rows_q) : row_q;
    col_w     = wrap ? 8'd0 : col_q;
    wrap_byte = lcdw_pkg::addr_cmd(row_w, 8'd0);
    row_d     = row_q;
    col_d     = col_q;
    char_byte = 8'd0;
    char_rs   = lcdw_pkg::RS_CMD;
    if (lcdw_pkg::action_e'(in_req.action) == lcdw_pkg::ACT_CURSOR) begin
      row_d     = lcdw_pkg::fix_row({1'b0, in_req.row}, num_rows_q);
      col_d     = {1'b0, in_req.col};
      char_byte = lcdw_pkg::addr_cmd(row_d, col_d);
    end else if (in_req.char_code == lcdw_pkg::CH_NEWLINE) begin
      row_d     = lcdw_pkg::fix_row({1'b0, row_w} + 3'd1, num_rows_q);
      col_d     = col_w;
      char_byte = lcdw_pkg::addr_cmd(row_d, col_d);
    end else if (in_req.char_code == lcdw_pkg::CH_RETURN) begin
      // the row count may have shrunk since the cursor was placed
      row_d     = lcdw_pkg::fix_row({1'b0, row_w}, num_rows_q);
      col_d     = 8'd0;
      char_byte = lcdw_pkg::addr_cmd(row_d, col_d);
    end else begin
      row_d     = row_w;
      col_d     = (col_w != lcdw_pkg::COL_MAX) ? col_w + 8'd1 : col_w;
      char_byte = in_req.char_code;
      char_rs   = lcdw_pkg::RS_DATA;
    end
  end

  always_comb begin
    if (wrap && (lcdw_pkg::action_e'(in_req.action) == lcdw_pkg::ACT_PRINT)) begin
      push_req_o.byte0 = wrap_byte;
      push_req_o.rs0   = lcdw_pkg::RS_CMD;
      push_req_o.byte1 = char_byte;
      push_req_o.rs1   = char_rs;
      push_req_o.two   = 1'b1;
    end else begin
      push_req_o.byte0 = char_byte;
      push_req_o.rs0   = char_rs;
      push_req_o.byte1 = char_byte;
      push_req_o.rs1   = char_rs;
      push_req_o.two   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 8'd0;
      row_q <= 2'd0;
    end else if (push_o) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: rtl/core/lcdw_queue.sv
// Two-entry request queue between front and back end
module lcdw_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lcdw_pkg::byte_req_t push_req_i,
  output logic               push_ready_o,
  input  logic               pop_i,
  output lcdw_pkg::byte_req_t head_o,
  output logic               empty_o
);

  lcdw_pkg::byte_req_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign push_ready_o = (cnt_q != 2'd2);
  assign empty_o      = (cnt_q == 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/core/lcdw_back.sv
// Back end: splits queued bytes into nibbles, high first, into an output register
module lcdw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcdw_pkg::byte_req_t head_i,
  input  logic               empty_i,
  output logic               pop_o,
  lcdw_out_if.source         out_nib
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [3:0] nibble_q;
  logic       rs_q;
  logic       last_q;

  logic       load;
  logic       final_nib;
  logic [7:0] cur_byte;
  lcdw_pkg::reg_sel_e cur_rs;

  assign cur_byte  = idx_q[1] ? head_i.byte1 : head_i.byte0;
  assign cur_rs    = idx_q[1] ? head_i.rs1 : head_i.rs0;
  assign final_nib = head_i.two ? (idx_q == 2'd3) : idx_q[0];
  assign load      = !empty_i && (!valid_q || out_nib.ready);
  assign pop_o     = load && final_nib;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        idx_q <= 2'd0;
      end else if (load) begin
        idx_q <= idx_q + 2'd1;
      end
      if (!valid_q || out_nib.ready) begin
        valid_q <= !empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      nibble_q <= idx_q[0] ? cur_byte[3:0] : cur_byte[7:4];
      rs_q     <= cur_rs;
      last_q   <= final_nib;
    end
  end

  assign out_nib.valid      = valid_q;
  assign out_nib.nibble     = nibble_q;
  assign out_nib.reg_select = rs_q;
  assign out_nib.last       = last_q;

endmodule

FILE: rtl/core/char_lcd_text_cursor_writer_top.sv
// Top level of the LCD text and cursor writer (4-bit bus, high nibble first)
//
//   channel   dir  handshake            payload
//   in_req    in   valid/ready          action, char_code, row, col
//   out_nib   out  valid/ready          nibble, reg_select, last
//   config    in   cfg_we_i             cfg_idx_i, cfg_data_i
//
// An item yields two or four nibbles; the output register sends one nibble a cycle
// while out_nib.ready is high. Requests are taken in any cycle the two-entry queue has
// room; each request is written into the queue and then loaded into the output register.
// Reset is asynchronous: cursor to row 0 column 0, rows 2, columns 16, wrap off.
// An output stall fills the queue and then holds in_req.ready low.
module char_lcd_text_cursor_writer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i,
  lcdw_in_if.sink    in_req,
  lcdw_out_if.source out_nib
);

  logic               push;
  logic               push_ready;
  lcdw_pkg::byte_req_t push_req;
  lcdw_pkg::byte_req_t head;
  logic               empty;
  logic               pop;

  lcdw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_req       (in_req),
    .push_o       (push),
    .push_req_o   (push_req),
    .push_ready_i (push_ready)
  );

  lcdw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_req_i   (push_req),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty)
  );

  lcdw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_nib (out_nib)
  );

endmodule

FILE: rtl/core/lcdw_checker.sv
// Port-level checker for the LCD text writer, bound to the top level
`include "char_lcd_text_cursor_writer_top_assert.svh"

module lcdw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] nibble_i,
  input logic       rs_i,
  input logic       last_i
);

  logic       acc;
  logic       stall;
  logic [5:0] payload;
  logic [1:0] pos_q;

  assign acc     = out_valid_i && out_ready_i;
  assign stall   = out_valid_i && !out_ready_i;
  assign payload = {nibble_i, rs_i, last_i};

  // position of the nibble within its request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else if (acc) begin
      pos_q <= last_i ? 2'd0 : pos_q + 2'd1;
    end
  end

  `LCDW_ASSERT(a_valid_hold, stall |=> out_valid_i, "valid dropped")
  `LCDW_ASSERT(a_data_hold, stall |=> $stable(payload), "payload changed")
  `LCDW_ASSERT(a_last_pos, acc && last_i |-> pos_q[0], "request not two or four nibbles")
  `LCDW_ASSERT(a_data_pos, acc && rs_i && !last_i |-> !pos_q[0], "data byte split")

endmodule

bind char_lcd_text_cursor_writer_top lcdw_checker u_lcdw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_nib.valid),
  .out_ready_i (out_nib.ready),
  .nibble_i    (out_nib.nibble),
  .rs_i        (out_nib.reg_select),
  .last_i      (out_nib.last)
);

FILE: verif/lcdw_nibble_checker.sv
// Checker for the LCD text writer: predicts the bus nibbles of each request and compares them
module lcdw_nibble_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i,
  lcdw_in_if         in_mon,
  lcdw_out_if        out_mon,
  output int         pending_o,
  output int         errors_o
);

  typedef struct {
    logic [3:0]         nib;
    lcdw_pkg::reg_sel_e rs;
    logic               last;
  } bus_nibble_t;

  bus_nibble_t nibbles_due[$];
  bus_nibble_t want;

  logic [2:0] rows_cfg;
  logic [6:0] cols_cfg;
  logic       wrap_cfg;
  logic [1:0] cur_row;
  logic [7:0] cur_col;

  int mismatches = 0;

  assign errors_o = mismatches;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] nibble check: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input lcdw_pkg::reg_sel_e rs);
    nibbles_due.push_back('{b[7:4], rs, 1'b0});
    nibbles_due.push_back('{b[3:0], rs, 1'b0});
  endtask

  // Move the cursor and queue the set-address command; r may run one past row 3
  task automatic move_cursor(input logic [2:0] r, input logic [7:0] c);
    logic [2:0] rr;
    logic [6:0] start;
    logic [6:0] addr;
    rr = ((r >= rows_cfg) || (r > 3'd3)) ? 3'd0 : r;
    cur_row = rr[1:0];
    cur_col = c;
    case (cur_row)
      2'd0: start = 7'h00;
      2'd1: start = 7'h40;
      2'd2: start = 7'h14;
      default: start = 7'h54;
    endcase
    addr = c[6:0] + start;
    queue_byte(lcdw_pkg::CMD_SET_DDRAM | {1'b0, addr}, lcdw_pkg::RS_CMD);
  endtask

  task automatic predict_bus_nibbles(input lcdw_pkg::action_e act, input logic [7:0] ch,
                                     input logic [1:0] r, input logic [6:0] c);
    bus_nibble_t tail;
    if (act == lcdw_pkg::ACT_CURSOR) begin
      move_cursor({1'b0, r}, {1'b0, c});
    end else begin
      if (wrap_cfg && (cur_col >= {1'b0, cols_cfg})) move_cursor({1'b0, cur_row} + 3'd1, 8'd0);
      if (ch == lcdw_pkg::CH_NEWLINE) begin
        move_cursor({1'b0, cur_row} + 3'd1, cur_col);
      end else if (ch == lcdw_pkg::CH_RETURN) begin
        move_cursor({1'b0, cur_row}, 8'd0);
      end else begin
        queue_byte(ch, lcdw_pkg::RS_DATA);
        if (cur_col != lcdw_pkg::COL_MAX) cur_col = cur_col + 8'd1;
      end
    end
    // mark the final nibble of this request
    tail = nibbles_due.pop_back();
    tail.last = 1'b1;
    nibbles_due.push_back(tail);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      nibbles_due.delete();
      rows_cfg = lcdw_pkg::NUM_ROWS_RST;
      cols_cfg = lcdw_pkg::NUM_COLS_RST;
      wrap_cfg = 1'b0;
      cur_row  = 2'd0;
      cur_col  = 8'd0;
    end else begin
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          lcdw_pkg::CFG_NUM_ROWS: rows_cfg = cfg_data_i[2:0];
          lcdw_pkg::CFG_NUM_COLS: cols_cfg = cfg_data_i;
          lcdw_pkg::CFG_WRAP_EN:  wrap_cfg = cfg_data_i[0];
          default: ;
        endcase
      end
      // check the output before taking a new request: a request cannot answer on its own edge
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (nibbles_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected nibble %h rs %b last %b",
                                  out_mon.nibble, out_mon.reg_select, out_mon.last));
        end else begin
          want = nibbles_due.pop_front();
          if (out_mon.nibble !== want.nib)
            flag_mismatch($sformatf("nibble %h, want %h", out_mon.nibble, want.nib));
          if (out_mon.reg_select !== want.rs)
            flag_mismatch($sformatf("reg_select %b, want %b", out_mon.reg_select, want.rs));
          if (out_mon.last !== want.last)
            flag_mismatch($sformatf("last %b, want %b", out_mon.last, want.last));
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        predict_bus_nibbles(lcdw_pkg::action_e'(in_mon.action), in_mon.char_code,
                            in_mon.row, in_mon.col);
    end
    pending_o = nibbles_due.size();
  end

endmodule

FILE: verif/tb.sv
// Testbench top for the LCD text writer: reset, register settings, requests and verdict
module tb;

  localparam int LIMIT_CYCLES = 100_000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [6:0] cfg_data_i;

  int pending;
  int errors;
  int hold_cycles = 0;
  bit gaps_on = 1'b1;

  lcdw_in_if  in_req ();
  lcdw_out_if out_nib ();

  char_lcd_text_cursor_writer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req     (in_req),
    .out_nib    (out_nib)
  );

  lcdw_nibble_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_mon     (in_req),
    .out_mon    (out_nib),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  always #2 clk_i = ~clk_i;

  // Nibble receiver: long hold-off when asked, else random stalls
  initial begin
    out_nib.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_nib.ready = 1'b0;
        hold_cycles--;
      end else begin
        out_nib.ready = !(gaps_on && ($urandom_range(99) < 11));
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 4);
    $display("char_lcd_text_cursor_writer_top: mismatch");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic set_display(input int n_rows, input int n_cols, input bit wrap);
    write_reg(lcdw_pkg::CFG_NUM_ROWS, 7'(n_rows));
    write_reg(lcdw_pkg::CFG_NUM_COLS, 7'(n_cols));
    write_reg(lcdw_pkg::CFG_WRAP_EN, {6'($urandom_range(63)), wrap});
  endtask

  // Offer one request and hold it until taken; entered and left at a falling edge
  task automatic send_req(input lcdw_pkg::action_e act, input logic [7:0] ch,
                          input logic [1:0] r, input logic [6:0] c);
    if (gaps_on && ($urandom_range(99) < 11)) begin
      in_req.valid     = 1'b0;
      in_req.char_code = 8'($urandom_range(255));
      in_req.row       = 2'($urandom_range(3));
      in_req.col       = 7'($urandom_range(127));
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_req.valid     = 1'b1;
    in_req.action    = act;
    in_req.char_code = ch;
    in_req.row       = r;
    in_req.col       = c;
    @(posedge clk_i);
    while (in_req.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_text(input logic [7:0] ch);
    send_req(lcdw_pkg::ACT_PRINT, ch, 2'($urandom_range(3)), 7'($urandom_range(127)));
  endtask

  task automatic send_cursor(input logic [1:0] r, input logic [6:0] c);
    send_req(lcdw_pkg::ACT_CURSOR, 8'($urandom_range(255)), r, c);
  endtask

  task automatic wait_all_nibbles();
    in_req.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_random_req(input bit text_only);
    int pick;
    logic [7:0] ch;
    pick = $urandom_range(99);
    ch   = 8'($urandom_range(255));
    if (text_only) begin
      // no carriage return here, so the column keeps climbing
      send_text((ch == lcdw_pkg::CH_RETURN) ? 8'h2A : ch);
    end else if (pick < 20) begin
      send_cursor(2'($urandom_range(3)), 7'($urandom_range(127)));
    end else if (pick < 30) begin
      send_text(lcdw_pkg::CH_NEWLINE);
    end else if (pick < 40) begin
      send_text(lcdw_pkg::CH_RETURN);
    end else begin
      send_text(ch);
    end
  endtask

  task automatic run_phase(input int n_rows, input int n_cols, input bit wrap, input int items,
                           input int hold, input bit idle, input bit text_only);
    wait_all_nibbles();
    set_display(n_rows, n_cols, wrap);
    gaps_on = idle;
    hold_cycles = hold;
    repeat (items) send_random_req(text_only);
    wait_all_nibbles();
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = lcdw_pkg::CFG_NUM_ROWS;
    cfg_data_i       = 7'd0;
    in_req.valid     = 1'b0;
    in_req.action    = lcdw_pkg::ACT_PRINT;
    in_req.char_code = 8'd0;
    in_req.row       = 2'd0;
    in_req.col       = 7'd0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: two rows, sixteen columns, no wrap
    send_cursor(2'd0, 7'd0);
    send_cursor(2'd1, 7'd79);    // address runs past 7 bits
    send_cursor(2'd3, 7'd127);   // row past the row count
    send_cursor(2'd2, 7'd5);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(lcdw_pkg::CH_NEWLINE);
    send_text(lcdw_pkg::CH_NEWLINE);   // next row falls off the display
    send_text(lcdw_pkg::CH_RETURN);
    send_text(8'h41);
    wait_all_nibbles();

    set_display(4, 80, 1'b1);
    write_reg(2'd3, 7'($urandom_range(127)));  // no such register: ignore
    send_cursor(2'd3, 7'd79);
    send_text(8'h78);
    send_text(8'h79);            // wrap from the last row back to the first
    send_cursor(2'd2, 7'd79);
    send_text(8'h61);
    send_text(lcdw_pkg::CH_NEWLINE);   // wrap and newline together
    send_text(lcdw_pkg::CH_RETURN);
    wait_all_nibbles();

    set_display(0, 0, 1'b1);     // no rows, zero width
    send_text(8'h7A);
    send_text(lcdw_pkg::CH_NEWLINE);
    send_text(lcdw_pkg::CH_RETURN);
    send_cursor(2'd3, 7'd64);

    run_phase(7, 127, 1'b0, 260, 0, 1'b1, 1'b1);  // run the column up to its ceiling
    run_phase(7, 127, 1'b1, 10, 0, 1'b1, 1'b0);
    run_phase(4, 80, 1'b1, 40, 0, 1'b1, 1'b0);
    run_phase(1, 1, 1'b1, 30, 120, 1'b1, 1'b0);   // receiver holds off, queue fills
    run_phase(0, 0, 1'b1, 30, 0, 1'b0, 1'b0);
    run_phase(2, 16, 1'b0, 30, 0, 1'b1, 1'b0);
    repeat (4) begin
      run_phase($urandom_range(7), $urandom_range(127), 1'($urandom_range(1)), 20, 0, 1'b1,
                1'b0);
    end

    wait_all_nibbles();
    repeat (8) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("char_lcd_text_cursor_writer_top: match");
    end else begin
      $display("char_lcd_text_cursor_writer_top: mismatch");
    end
    $finish;
  end

endmodule
